[rtl/esd_pkg.sv]
// Shared types, constants and a helper function of the escape sequence decoder.
package esd_pkg;

  // Widths of the character, result, counter and APB fields.
  localparam int unsigned CharW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned ErrW   = 3;
  localparam int unsigned CountW = 4;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // Register map, one 32-bit word per register.
  localparam logic REG_WIDE  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  // Register reset values.
  localparam logic           WideReset  = 1'b0;
  localparam logic [CpW-1:0] LimitReset = CpW'(256);

  // Digit counts owed after the escape letter.
  localparam logic [CountW-1:0] Hex2Digits = CountW'(2);
  localparam logic [CountW-1:0] Hex4Digits = CountW'(4);
  localparam logic [CountW-1:0] Hex8Digits = CountW'(8);
  localparam logic [CountW-1:0] OctDigits  = CountW'(2);
  // Digits above this count of a \U escape are prefix digits.
  localparam logic [CountW-1:0] PrefixEnd  = CountW'(4);

  // Decoder phase.
  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_ESC        = 3'd1,
    PH_DIG        = 3'd2,
    PH_DIG_BAD    = 3'd3,
    PH_DIG_PREFIX = 3'd4
  } phase_e;

  // Kind of numeric escape being collected.
  typedef enum logic [1:0] {
    K_HEX2 = 2'd0,
    K_HEX4 = 2'd1,
    K_HEX8 = 2'd2,
    K_OCT  = 2'd3
  } kind_e;

  // Error codes reported with a result.
  typedef enum logic [ErrW-1:0] {
    ERR_NONE      = 3'd0,
    ERR_SHORT     = 3'd1,
    ERR_BAD_DIGIT = 3'd2,
    ERR_OCTAL     = 3'd3,
    ERR_PREFIX    = 3'd4,
    ERR_RANGE     = 3'd5
  } err_e;

  // Decoder state carried from one character to the next.
  typedef struct packed {
    phase_e            phase;
    logic [CountW-1:0] digits_left;
    logic [CpW-1:0]    acc;
    kind_e             kind;
  } esd_state_t;

  // One decoded result.
  typedef struct packed {
    logic [CpW-1:0] code_point;
    err_e           error;
  } esd_result_t;

  // Hex digit value; bit 4 set means the character is no hex digit.
  function automatic logic [4:0] hex_value(logic [CharW-1:0] c);
    logic [CharW-1:0] t;
    t = c;
    if (c >= "0" && c <= "9") begin
      t = c - "0";
    end else if (c >= "a" && c <= "f") begin
      t = c - "a" + CharW'(10);
    end else if (c >= "A" && c <= "F") begin
      t = c - "A" + CharW'(10);
    end else begin
      t = CharW'(16);
    end
    return t[4:0];
  endfunction

endpackage

[rtl/esd_char_if.sv]
// Stream interfaces for source characters and for decoded code points.
interface esd_char_if;
  logic                          valid;
  logic                          ready;
  logic [esd_pkg::CharW-1:0]     char_in;
  logic                          last;

  modport source (output valid, output char_in, output last, input ready);
  modport sink (input valid, input char_in, input last, output ready);
endinterface

interface esd_cp_if;
  logic                          valid;
  logic                          ready;
  logic [esd_pkg::CpW-1:0]       code_point;
  logic [esd_pkg::ErrW-1:0]      error;

  modport source (output valid, output code_point, output error, input ready);
  modport sink (input valid, input code_point, input error, output ready);
endinterface

[rtl/esd_step.sv]
// Next-state and result logic of the decoder for one character.
module esd_step (
  input  esd_pkg::esd_state_t          state_i,
  input  logic [esd_pkg::CharW-1:0]    char_i,
  input  logic                         last_i,
  input  logic                         wide_i,
  input  logic [esd_pkg::CpW-1:0]      limit_i,
  output esd_pkg::esd_state_t          state_o,
  output logic                         emit_o,
  output esd_pkg::esd_result_t         result_o
);

  logic [4:0]                   hex;
  logic                         hex_ok;
  logic                         oct_ok;
  logic                         prefix_chk;
  logic                         prefix_ok;
  logic                         digit_ok;
  logic [esd_pkg::CpW-1:0]      acc_nxt;
  logic [esd_pkg::CountW-1:0]   left_nxt;
  esd_pkg::phase_e              phase_dig;

  // Digit classification of the current character.
  always_comb begin
    hex        = esd_pkg::hex_value(char_i);
    hex_ok     = ~hex[4];
    oct_ok     = (char_i >= "0") && (char_i <= "7");
    prefix_chk = (state_i.kind == esd_pkg::K_HEX8) &&
                 (state_i.digits_left > esd_pkg::PrefixEnd);
    // The first two prefix digits must be zero; the next two name the plane.
    if (state_i.digits_left == esd_pkg::CountW'(6)) begin
      prefix_ok = (char_i == "0") || ((char_i == "1") && wide_i);
    end else if (state_i.digits_left == esd_pkg::CountW'(5)) begin
      prefix_ok = wide_i ? hex_ok : (char_i == "0");
    end else begin
      prefix_ok = (char_i == "0");
    end
    if (state_i.kind == esd_pkg::K_OCT) begin
      digit_ok = oct_ok;
      acc_nxt  = {state_i.acc[esd_pkg::CpW-4:0], (oct_ok ? char_i[2:0] : 3'd0)};
    end else begin
      digit_ok = prefix_chk ? prefix_ok : hex_ok;
      acc_nxt  = {state_i.acc[esd_pkg::CpW-5:0], (hex_ok ? hex[3:0] : 4'd0)};
    end
    left_nxt = state_i.digits_left - esd_pkg::CountW'(1);
    // A failed prefix outranks a bad digit; the first bad digit sticks.
    phase_dig = state_i.phase;
    if (!digit_ok) begin
      if (prefix_chk) begin
        phase_dig = esd_pkg::PH_DIG_PREFIX;
      end else if (state_i.phase == esd_pkg::PH_DIG) begin
        phase_dig = esd_pkg::PH_DIG_BAD;
      end
    end
  end

  // Phase transitions and result selection.
  always_comb begin
    state_o  = state_i;
    emit_o   = 1'b0;
    result_o = '{code_point: '0, error: esd_pkg::ERR_NONE};
    unique case (state_i.phase)
      esd_pkg::PH_ESC: begin
        state_o.phase = esd_pkg::PH_IDLE;
        emit_o        = 1'b1;
        unique case (char_i)
          "n": result_o.code_point = esd_pkg::CpW'(10);
          "t": result_o.code_point = esd_pkg::CpW'(9);
          "v": result_o.code_point = esd_pkg::CpW'(11);
          "b": result_o.code_point = esd_pkg::CpW'(8);
          "r": result_o.code_point = esd_pkg::CpW'(13);
          "f": result_o.code_point = esd_pkg::CpW'(12);
          "a": result_o.code_point = esd_pkg::CpW'(7);
          "x", "X", "u", "U", "0", "1", "2", "3": begin
            if (last_i) begin
              result_o.error = esd_pkg::ERR_SHORT;
            end else begin
              emit_o            = 1'b0;
              state_o.phase     = esd_pkg::PH_DIG;
              state_o.acc       = '0;
              if (char_i == "x") begin
                state_o.kind        = esd_pkg::K_HEX2;
                state_o.digits_left = esd_pkg::Hex2Digits;
              end else if (char_i == "U") begin
                state_o.kind        = esd_pkg::K_HEX8;
                state_o.digits_left = esd_pkg::Hex8Digits;
              end else if (char_i == "X" || char_i == "u") begin
                state_o.kind        = esd_pkg::K_HEX4;
                state_o.digits_left = esd_pkg::Hex4Digits;
              end else begin
                state_o.kind        = esd_pkg::K_OCT;
                state_o.digits_left = esd_pkg::OctDigits;
                state_o.acc         = esd_pkg::CpW'(char_i[1:0]);
              end
            end
          end
          "4", "5", "6", "7": result_o.error = esd_pkg::ERR_OCTAL;
          default: result_o.code_point = esd_pkg::CpW'(char_i);
        endcase
      end
      esd_pkg::PH_DIG, esd_pkg::PH_DIG_BAD, esd_pkg::PH_DIG_PREFIX: begin
        state_o.acc         = acc_nxt;
        state_o.digits_left = left_nxt;
        state_o.phase       = phase_dig;
        if (left_nxt == '0) begin
          // Final digit: report the escape's outcome.
          state_o.phase = esd_pkg::PH_IDLE;
          emit_o        = 1'b1;
          if (phase_dig == esd_pkg::PH_DIG_PREFIX) begin
            result_o.error = esd_pkg::ERR_PREFIX;
          end else if (phase_dig == esd_pkg::PH_DIG_BAD) begin
            result_o.error = esd_pkg::ERR_BAD_DIGIT;
          end else if ((state_i.kind == esd_pkg::K_HEX4 ||
                        state_i.kind == esd_pkg::K_HEX8) && (acc_nxt >= limit_i)) begin
            result_o.error = esd_pkg::ERR_RANGE;
          end else begin
            result_o.code_point = acc_nxt;
          end
        end else if (last_i) begin
          state_o.phase  = esd_pkg::PH_IDLE;
          emit_o         = 1'b1;
          result_o.error = esd_pkg::ERR_SHORT;
        end
      end
      default: begin
        // Idle: plain characters and a trailing backslash pass through.
        if (char_i != "\\" || last_i) begin
          state_o.phase       = esd_pkg::PH_IDLE;
          emit_o              = 1'b1;
          result_o.code_point = esd_pkg::CpW'(char_i);
        end else begin
          state_o.phase = esd_pkg::PH_ESC;
        end
      end
    endcase
  end

endmodule

[rtl/escape_sequence_decoder.sv]
// Top level of the escape sequence decoder: stages, state and registers.
//
// The decoder takes the characters of a C-style literal, one per transfer on
// char_i, with last marking the final character, and gives decoded code points
// with an error code on cp_o. A character yields zero or one result.
// An accepted character lands in an input register; when the result register
// is free or draining, the decode logic updates the escape state and loads
// the result register, which then offers the result of a character that
// completes one. One character is taken per cycle while the receiver keeps
// up; the state update between the input and result registers sets that rate.
// When the receiver stalls, the result register holds its transfer and the
// input register still takes one more character; after that char_i.ready
// drops until the result moves on. Reset empties both registers, returns the
// decoder to idle and sets wide_code_points to 0 and code_point_limit to 256.
// The two registers are written over the APB port at byte addresses 0 and 4,
// by the user only while the block is idle; the block does not enforce it.
module escape_sequence_decoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  esd_char_if.sink                        char_i,
  esd_cp_if.source                        cp_o,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic [esd_pkg::ApbAddrW-1:0]    paddr_i,
  input  logic [esd_pkg::ApbDataW-1:0]    pwdata_i,
  output logic [esd_pkg::ApbDataW-1:0]    prdata_o,
  output logic                            pready_o
);

  logic                          wide_q;
  logic [esd_pkg::CpW-1:0]       limit_q;
  logic                          cfg_wr;

  logic                          in_valid_q, in_valid_d;
  logic [esd_pkg::CharW-1:0]     char_q;
  logic                          last_q;
  logic                          in_xfer;
  logic                          advance;

  esd_pkg::esd_state_t           state_q, state_d;
  logic                          emit;
  esd_pkg::esd_result_t          result;

  logic                          out_valid_q, out_valid_d;
  esd_pkg::esd_result_t          out_q;

  // Configuration registers.
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q  <= esd_pkg::WideReset;
      limit_q <= esd_pkg::LimitReset;
    end else if (cfg_wr) begin
      if (paddr_i[2] == esd_pkg::REG_WIDE) begin
        wide_q <= pwdata_i[0];
      end else begin
        limit_q <= pwdata_i[esd_pkg::CpW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr_i[2] == esd_pkg::REG_LIMIT) begin
      prdata_o = esd_pkg::ApbDataW'(limit_q);
    end else begin
      prdata_o = esd_pkg::ApbDataW'(wide_q);
    end
  end

  // Input stage moves on whenever the result register is free or draining.
  assign advance      = in_valid_q && (!out_valid_q || cp_o.ready);
  assign char_i.ready = !in_valid_q || advance;
  assign in_xfer      = char_i.valid && char_i.ready;
  assign in_valid_d   = in_xfer || (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      char_q <= char_i.char_in;
      last_q <= char_i.last;
    end
  end

  // Decode of the registered character.
  esd_step u_step (
    .state_i  (state_q),
    .char_i   (char_q),
    .last_i   (last_q),
    .wide_i   (wide_q),
    .limit_i  (limit_q),
    .state_o  (state_d),
    .emit_o   (emit),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: esd_pkg::PH_IDLE, digits_left: '0, acc: '0,
                   kind: esd_pkg::K_HEX2};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_comb begin
    if (advance) begin
      out_valid_d = emit;
    end else if (cp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q <= result;
    end
  end

  assign cp_o.valid      = out_valid_q;
  assign cp_o.code_point = out_q.code_point;
  assign cp_o.error      = out_q.error;

endmodule

[rtl/esd_checker.sv]
// Port-level assertions of the escape sequence decoder and their binding.
module esd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [esd_pkg::CpW-1:0]      code_point_i,
  input logic [esd_pkg::ErrW-1:0]     error_i
);

  // A reported error never carries a code point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (error_i != esd_pkg::ERR_NONE) |-> code_point_i == '0)
    else $error("code point not zero with an error");

  // Only the defined error codes appear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> error_i <= esd_pkg::ERR_RANGE)
    else $error("undefined error code");

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(code_point_i) && $stable(error_i))
    else $error("result changed while stalled");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (cp_o.valid),
  .out_ready_i  (cp_o.ready),
  .code_point_i (cp_o.code_point),
  .error_i      (cp_o.error)
);

[bench/testbench.sv]
// Self-checking testbench of the escape sequence decoder, with a predictor and stream checks.
`timescale 1ns / 1ps

module testbench;

  localparam int QuietLimit   = 2000;
  localparam int PhaseChars   = 145;
  localparam int SettleCycles = 10;
  localparam int HoldAfter    = 300;
  localparam int HoldCycles   = 150;
  localparam int GapPct       = 33;

  // Byte addresses of the two registers.
  localparam logic [esd_pkg::ApbAddrW-1:0] AddrWide  = {esd_pkg::REG_WIDE, 2'b00};
  localparam logic [esd_pkg::ApbAddrW-1:0] AddrLimit = {esd_pkg::REG_LIMIT, 2'b00};

  // Escape letters with a fixed control code.
  localparam logic [esd_pkg::CharW-1:0] SimpleEsc [7] =
    '{"n", "t", "v", "b", "r", "f", "a"};

  typedef struct packed {
    logic [esd_pkg::CharW-1:0] ch;
    logic                      lst;
  } char_item_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         psel_i;
  logic                         penable_i;
  logic                         pwrite_i;
  logic [esd_pkg::ApbAddrW-1:0] paddr_i;
  logic [esd_pkg::ApbDataW-1:0] pwdata_i;
  logic [esd_pkg::ApbDataW-1:0] prdata_o;
  logic                         pready_o;

  esd_char_if chr ();
  esd_cp_if   cpo ();

  escape_sequence_decoder dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .char_i    (chr),
    .cp_o      (cpo),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  char_item_t                chars_to_send[$];
  esd_pkg::esd_result_t      predicted_cps[$];
  logic [esd_pkg::CharW-1:0] lit_q[$];
  char_item_t                next_char;
  esd_pkg::esd_result_t      want;

  logic calm;
  int   errors = 0;
  int   results_seen = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  int   quiet = 0;

  // Predictor state and its copy of the registers.
  esd_pkg::phase_e         dec_phase = esd_pkg::PH_IDLE;
  esd_pkg::kind_e          dec_kind  = esd_pkg::K_HEX2;
  logic [3:0]              dec_left  = '0;
  logic [esd_pkg::CpW-1:0] dec_acc   = '0;
  logic                    cfg_wide  = 1'b0;
  logic [esd_pkg::CpW-1:0] cfg_limit = esd_pkg::CpW'(256);

  // Value of a hex digit; bit 4 marks a byte that is no hex digit.
  function automatic logic [4:0] digit_of(logic [esd_pkg::CharW-1:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
    return 5'd16;
  endfunction

  function automatic void note_result(logic [esd_pkg::CpW-1:0] cp, esd_pkg::err_e err);
    esd_pkg::esd_result_t r;
    r.code_point = (err == esd_pkg::ERR_NONE) ? cp : '0;
    r.error      = err;
    predicted_cps.push_back(r);
  endfunction

  // Start collecting digits, or report a literal that ends on the escape letter.
  function automatic void open_digits(logic lst, esd_pkg::kind_e k, logic [3:0] n,
                                      logic [esd_pkg::CpW-1:0] init);
    if (lst) begin
      dec_phase = esd_pkg::PH_IDLE;
      note_result('0, esd_pkg::ERR_SHORT);
    end else begin
      dec_phase = esd_pkg::PH_DIG;
      dec_kind  = k;
      dec_left  = n;
      dec_acc   = init;
    end
  endfunction

  // Advance the decoder by one transferred character.
  function automatic void decode_char(logic [esd_pkg::CharW-1:0] c, logic lst);
    logic [4:0]              h;
    logic [esd_pkg::CpW-1:0] d;
    int                      shift;
    int                      pos;
    esd_pkg::err_e           fail;
    logic                    ok;
    esd_pkg::phase_e         p;
    case (dec_phase)
      esd_pkg::PH_ESC: begin
        dec_phase = esd_pkg::PH_IDLE;
        case (c)
          "n": note_result(esd_pkg::CpW'(10), esd_pkg::ERR_NONE);
          "t": note_result(esd_pkg::CpW'(9), esd_pkg::ERR_NONE);
          "v": note_result(esd_pkg::CpW'(11), esd_pkg::ERR_NONE);
          "b": note_result(esd_pkg::CpW'(8), esd_pkg::ERR_NONE);
          "r": note_result(esd_pkg::CpW'(13), esd_pkg::ERR_NONE);
          "f": note_result(esd_pkg::CpW'(12), esd_pkg::ERR_NONE);
          "a": note_result(esd_pkg::CpW'(7), esd_pkg::ERR_NONE);
          "x": open_digits(lst, esd_pkg::K_HEX2, esd_pkg::Hex2Digits, '0);
          "X", "u": open_digits(lst, esd_pkg::K_HEX4, esd_pkg::Hex4Digits, '0);
          "U": open_digits(lst, esd_pkg::K_HEX8, esd_pkg::Hex8Digits, '0);
          "4", "5", "6", "7": note_result('0, esd_pkg::ERR_OCTAL);
          "0", "1", "2", "3":
            open_digits(lst, esd_pkg::K_OCT, esd_pkg::OctDigits, esd_pkg::CpW'(c - "0"));
          default: note_result(esd_pkg::CpW'(c), esd_pkg::ERR_NONE);
        endcase
      end
      esd_pkg::PH_DIG, esd_pkg::PH_DIG_BAD, esd_pkg::PH_DIG_PREFIX: begin
        shift = 4;
        fail  = esd_pkg::ERR_BAD_DIGIT;
        h     = digit_of(c);
        if (dec_kind == esd_pkg::K_OCT) begin
          ok    = (c >= "0" && c <= "7");
          d     = ok ? esd_pkg::CpW'(c - "0") : '0;
          shift = 3;
        end else begin
          d = h[4] ? '0 : esd_pkg::CpW'(h[3:0]);
          if (dec_kind == esd_pkg::K_HEX8 && dec_left > 4) begin
            // Prefix window of a \U escape.
            pos  = 8 - int'(dec_left);
            fail = esd_pkg::ERR_PREFIX;
            if (pos < 2) ok = (c == "0");
            else if (pos == 2) ok = (c == "0") || (c == "1" && cfg_wide);
            else ok = cfg_wide ? !h[4] : (c == "0");
          end else begin
            ok = !h[4];
          end
        end
        if (!ok) begin
          if (fail == esd_pkg::ERR_PREFIX) dec_phase = esd_pkg::PH_DIG_PREFIX;
          else if (dec_phase == esd_pkg::PH_DIG) dec_phase = esd_pkg::PH_DIG_BAD;
        end
        dec_acc  = (dec_acc << shift) | d;
        dec_left = dec_left - 4'd1;
        if (dec_left == 0) begin
          p         = dec_phase;
          dec_phase = esd_pkg::PH_IDLE;
          if (p == esd_pkg::PH_DIG_PREFIX) note_result('0, esd_pkg::ERR_PREFIX);
          else if (p == esd_pkg::PH_DIG_BAD) note_result('0, esd_pkg::ERR_BAD_DIGIT);
          else if ((dec_kind == esd_pkg::K_HEX4 || dec_kind == esd_pkg::K_HEX8) &&
                   dec_acc >= cfg_limit)
            note_result('0, esd_pkg::ERR_RANGE);
          else note_result(dec_acc, esd_pkg::ERR_NONE);
        end else if (lst) begin
          dec_phase = esd_pkg::PH_IDLE;
          note_result('0, esd_pkg::ERR_SHORT);
        end
      end
      default: begin
        dec_phase = esd_pkg::PH_IDLE;
        if (c != "\\" || lst) note_result(esd_pkg::CpW'(c), esd_pkg::ERR_NONE);
        else dec_phase = esd_pkg::PH_ESC;
      end
    endcase
  endfunction

  function automatic logic [esd_pkg::CharW-1:0] hex_char(logic [3:0] v);
    if (v < 10) return "0" + esd_pkg::CharW'(v);
    return ($urandom_range(1) ? "a" : "A") + esd_pkg::CharW'(v) - 8'd10;
  endfunction

  // A hex digit, now and then replaced by an arbitrary byte.
  function automatic logic [esd_pkg::CharW-1:0] value_digit();
    if ($urandom_range(19) == 0) return esd_pkg::CharW'($urandom_range(255));
    return hex_char(4'($urandom_range(15)));
  endfunction

  // Leading digits lean toward zero so that small limits are reached.
  function automatic logic [esd_pkg::CharW-1:0] lead_digit();
    if ($urandom_range(1)) return "0";
    return value_digit();
  endfunction

  // The four prefix digits of a \U escape: narrow, wide or broken.
  function automatic void add_wide_prefix();
    int sel;
    int i;
    sel = $urandom_range(9);
    if (sel < 5) begin
      for (i = 0; i < 4; i++) lit_q.push_back("0");
    end else if (sel < 8) begin
      lit_q.push_back("0");
      lit_q.push_back("0");
      lit_q.push_back($urandom_range(1) ? "1" : "0");
      lit_q.push_back(hex_char(4'($urandom_range(15))));
    end else begin
      for (i = 0; i < 4; i++) lit_q.push_back(value_digit());
    end
  endfunction

  // One plain character or one escape sequence of the literal being built.
  function automatic void add_escape_unit();
    int                        sel;
    int                        i;
    logic [esd_pkg::CharW-1:0] c;
    sel = $urandom_range(99);
    if (sel < 25) begin
      c = esd_pkg::CharW'($urandom_range(255));
      if (c == "\\") lit_q.push_back("\\");
      lit_q.push_back(c);
    end else begin
      lit_q.push_back("\\");
      if (sel < 40) begin
        lit_q.push_back(SimpleEsc[$urandom_range(6)]);
      end else if (sel < 47) begin
        lit_q.push_back(esd_pkg::CharW'($urandom_range(255)));
      end else if (sel < 57) begin
        lit_q.push_back("x");
        for (i = 0; i < 2; i++) lit_q.push_back(value_digit());
      end else if (sel < 70) begin
        lit_q.push_back($urandom_range(1) ? "X" : "u");
        for (i = 0; i < 4; i++) lit_q.push_back(i < 2 ? lead_digit() : value_digit());
      end else if (sel < 85) begin
        lit_q.push_back("U");
        add_wide_prefix();
        for (i = 0; i < 4; i++) lit_q.push_back(i < 2 ? lead_digit() : value_digit());
      end else if (sel < 90) begin
        lit_q.push_back(esd_pkg::CharW'("4" + $urandom_range(3)));
      end else begin
        lit_q.push_back(esd_pkg::CharW'("0" + $urandom_range(3)));
        for (i = 0; i < 2; i++) begin
          if ($urandom_range(19) == 0) lit_q.push_back(esd_pkg::CharW'($urandom_range(255)));
          else lit_q.push_back(esd_pkg::CharW'("0" + $urandom_range(7)));
        end
      end
    end
  endfunction

  // Build one literal, mostly well formed, sometimes noise or cut short.
  task automatic add_literal(output int added);
    int units;
    int cut;
    int i;
    lit_q.delete();
    if ($urandom_range(9) == 0) begin
      units = $urandom_range(8, 1);
      for (i = 0; i < units; i++)
        lit_q.push_back($urandom_range(3) == 0 ? "\\" : esd_pkg::CharW'($urandom_range(255)));
    end else begin
      units = $urandom_range(5, 1);
      for (i = 0; i < units; i++) add_escape_unit();
      if ($urandom_range(6) == 0) begin
        cut = $urandom_range(lit_q.size(), 1);
        while (lit_q.size() > cut) void'(lit_q.pop_back());
      end
    end
    // A lone backslash at the very end stays a backslash.
    if ($urandom_range(19) == 0) lit_q.push_back("\\");
    for (i = 0; i < lit_q.size(); i++)
      chars_to_send.push_back('{ch: lit_q[i], lst: (i == lit_q.size() - 1)});
    added = lit_q.size();
  endtask

  task automatic fill(input int n);
    int added;
    int total;
    total = 0;
    while (total < n) begin
      add_literal(added);
      total += added;
    end
  endtask

  task automatic add_text(input string s, input bit ends);
    int i;
    for (i = 0; i < s.len(); i++)
      chars_to_send.push_back('{ch: s[i], lst: ends && (i == s.len() - 1)});
  endtask

  // Wait until every character is sent and every result has come back.
  task automatic settle();
    while (chars_to_send.size() > 0 || chr.valid || predicted_cps.size() > 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle.
  task automatic write_reg(input logic [esd_pkg::ApbAddrW-1:0] addr,
                           input logic [esd_pkg::ApbDataW-1:0] val);
    @(posedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= addr;
    pwdata_i  <= val;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    if (addr == AddrWide) cfg_wide = val[0];
    else cfg_limit = val[esd_pkg::CpW-1:0];
  endtask

  task automatic run_phase(input logic wide, input logic [esd_pkg::CpW-1:0] limit,
                           input logic no_gaps);
    settle();
    write_reg(AddrWide, esd_pkg::ApbDataW'(wide));
    write_reg(AddrLimit, esd_pkg::ApbDataW'(limit));
    calm <= no_gaps;
    @(negedge clk_i);
    fill(PhaseChars);
  endtask

  // Character driver; the predictor runs on every transfer.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      chr.valid   <= 1'b0;
      chr.char_in <= '0;
      chr.last    <= 1'b0;
    end else begin
      if (chr.valid && chr.ready) decode_char(chr.char_in, chr.last);
      if (!chr.valid || chr.ready) begin
        if (chars_to_send.size() > 0 && (calm || $urandom_range(99) >= GapPct)) begin
          next_char = chars_to_send.pop_front();
          chr.valid   <= 1'b1;
          chr.char_in <= next_char.ch;
          chr.last    <= next_char.lst;
        end else begin
          chr.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random stalls and one long hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cpo.ready <= 1'b0;
    end else begin
      if (cpo.valid && cpo.ready) begin
        results_seen++;
        if (predicted_cps.size() == 0) begin
          $error("unexpected result: code_point %0d error %0d", cpo.code_point, cpo.error);
          errors++;
        end else begin
          want = predicted_cps.pop_front();
          if (cpo.code_point !== want.code_point) begin
            $error("code_point: expected %0d, actual %0d", want.code_point, cpo.code_point);
            errors++;
          end
          if (cpo.error !== want.error) begin
            $error("error: expected %0d, actual %0d", want.error, cpo.error);
            errors++;
          end
        end
      end
      if (!hold_done && results_seen >= HoldAfter && chars_to_send.size() > 20) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        cpo.ready <= 1'b0;
      end else begin
        cpo.ready <= calm || $urandom_range(99) >= GapPct;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (chr.valid && chr.ready) || (cpo.valid && cpo.ready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Reset, directed literals, then random phases under several settings.
  initial begin
    rst_ni      = 1'b0;
    calm        = 1'b0;
    chr.valid   = 1'b0;
    chr.char_in = '0;
    chr.last    = 1'b0;
    cpo.ready   = 1'b0;
    psel_i      = 1'b0;
    penable_i   = 1'b0;
    pwrite_i    = 1'b0;
    paddr_i     = '0;
    pwdata_i    = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Byte extremes, simple, two- and four-digit hex and octal escapes, errors and a lone backslash.
    chars_to_send.push_back('{ch: 8'h00, lst: 1'b0});
    chars_to_send.push_back('{ch: 8'hFF, lst: 1'b0});
    add_text("\\n", 1'b0);
    add_text("\\x4f", 1'b0);
    add_text("\\7", 1'b0);
    add_text("\\377", 1'b0);
    add_text("\\u", 1'b1);
    add_text("\\z", 1'b0);
    add_text("\\X00G1", 1'b0);
    add_text("\\", 1'b1);
    fill(PhaseChars);

    run_phase(1'b1, esd_pkg::CpW'(1114112), 1'b0);
    run_phase(1'b0, esd_pkg::CpW'(1), 1'b1);
    run_phase(1'b1, esd_pkg::CpW'(65536), 1'b0);
    run_phase(1'b1, esd_pkg::CpW'($urandom_range(1114112, 1)), 1'b0);
    run_phase(1'b0, esd_pkg::CpW'(1114112), 1'b0);
    settle();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/esd_pkg.sv
rtl/esd_char_if.sv
rtl/esd_step.sv
rtl/escape_sequence_decoder.sv
rtl/esd_checker.sv
bench/testbench.sv
